// ===== sv/fccm_pkg.sv =====
// fccm_pkg: shared constants, codes and helpers of the FAT16 cluster chain manager
// used by the channel interfaces and the top level; depends on nothing
package fccm_pkg;

   localparam int TABLE_DEPTH = 2048;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int CSR_IDX_W   = 4;

   typedef logic [1:0]           cmd_type;
   typedef logic [1:0]           status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam cmd_type CMD_READ  = 2'd0;
   localparam cmd_type CMD_WRITE = 2'd1;
   localparam cmd_type CMD_ALLOC = 2'd2;
   localparam cmd_type CMD_FREE  = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

   localparam csr_idx_type CSR_DATA_START = 4'd0;
   localparam csr_idx_type CSR_SECTORS    = 4'd1;

   localparam logic [15:0] FREE_ENTRY  = 16'h0000;
   localparam logic [15:0] CHAIN_END   = 16'hFFFF;
   localparam logic [15:0] CHAIN_LIMIT = 16'hFFF8;

   function automatic logic in_table(input logic [15:0] c);
      in_table = ({16'd0, c} < 32'(TABLE_DEPTH));
   endfunction

endpackage

// ===== sv/fccm_if.sv =====
// channel interfaces of the cluster chain manager: command, result and register write
// depends on fccm_pkg for field types
interface fccm_req_if;
   logic                 valid;
   logic                 ready;
   fccm_pkg::cmd_type    command;
   logic [15:0]          cluster;
   logic [15:0]          link_cluster;
   logic [15:0]          entry_value;

   modport source (output valid, command, cluster, link_cluster, entry_value, input ready);
   modport sink (input valid, command, cluster, link_cluster, entry_value, output ready);
endinterface

interface fccm_rsp_if;
   logic                 valid;
   logic                 ready;
   fccm_pkg::status_type status;
   logic [15:0]          result_value;
   logic [31:0]          sector_address;

   modport source (output valid, status, result_value, sector_address, input ready);
   modport sink (input valid, status, result_value, sector_address, output ready);
endinterface

interface fccm_csr_if;
   logic                  valid;
   logic                  ready;
   fccm_pkg::csr_idx_type index;
   logic [31:0]           data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/fat_cluster_chain_manager_unit.sv =====
// fat_cluster_chain_manager_unit: FAT16 allocation table with read, write, allocate, free
// depends on fccm_pkg and the channel interfaces in fccm_if.sv
//
//  channel   dir  moves                                         handshake
//  req_ch    in   command, cluster, link_cluster, entry_value   valid/ready
//  rsp_ch    out  status, result_value, sector_address          valid/ready
//  csr_ch    in   index, data (register write)                  valid/ready, always ready
//
// one item at a time through a sequencer around the single-port table memory
// read: the entry is read, then its sector address is summed; write: the entry is written
// allocate: scans up from cluster 2, one entry per cycle read, plus a link write when a link
// is given; free: one read and one write per cluster freed, since each link needs both
// after reset a clearing pass zeroes the table; no item is taken then
// a result waiting in the output register stalls only the end of the following item
module fat_cluster_chain_manager_unit (
   input logic          clock,
   input logic          reset,
   fccm_req_if.sink     req_ch,
   fccm_rsp_if.source   rsp_ch,
   fccm_csr_if.sink     csr_ch
);

   localparam int IDX_W = fccm_pkg::IDX_W;
   localparam int CNT_W = fccm_pkg::CNT_W;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_RD_DATA  = 4'd2;
   localparam logic [3:0] S_RD_SUM   = 4'd3;
   localparam logic [3:0] S_SCAN     = 4'd4;
   localparam logic [3:0] S_LINK     = 4'd5;
   localparam logic [3:0] S_FREE_CHK = 4'd6;
   localparam logic [3:0] S_FREE_WR  = 4'd7;
   localparam logic [3:0] S_RESP     = 4'd8;

   logic [15:0]       mem [fccm_pkg::TABLE_DEPTH];
   logic [15:0]       rd_data_ff;
   logic              mem_we;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_addr;
   logic [15:0]       mem_wdata;

   logic [3:0]        state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [15:0]       cl_ff, cl_in;
   logic [15:0]       prev_ff, prev_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [IDX_W-1:0]  chk_addr_ff, chk_addr_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [23:0]       prod_ff, prod_in;

   fccm_pkg::status_type pend_status_ff, pend_status_in;
   logic [15:0]          pend_value_ff, pend_value_in;
   logic [31:0]          pend_sector_ff, pend_sector_in;
   fccm_pkg::cmd_type    cmd_ff, cmd_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   fccm_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [15:0]          rsp_value_ff, rsp_value_in;
   logic [31:0]          rsp_sector_ff, rsp_sector_in;

   logic [31:0]       dstart_ff;
   logic [7:0]        sic_ff;

   logic              req_acc;
   logic              slot_free;

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign req_acc       = req_ch.valid && req_ch.ready;
   assign slot_free     = !rsp_valid_ff || rsp_ch.ready;

   assign csr_ch.ready          = 1'b1;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.result_value   = rsp_value_ff;
   assign rsp_ch.sector_address = rsp_sector_ff;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      cl_in          = cl_ff;
      prev_in        = prev_ff;
      scan_in        = scan_ff;
      chk_addr_in    = chk_addr_ff;
      chk_vld_in     = chk_vld_ff;
      cnt_in         = cnt_ff;
      prod_in        = prod_ff;
      cmd_in         = cmd_ff;
      pend_status_in = pend_status_ff;
      pend_value_in  = pend_value_ff;
      pend_sector_in = pend_sector_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_sector_in  = rsp_sector_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = '0;
      mem_wdata      = fccm_pkg::FREE_ENTRY;

      case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(fccm_pkg::TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               cmd_in         = req_ch.command;
               cl_in          = req_ch.cluster;
               prev_in        = req_ch.link_cluster;
               pend_status_in = fccm_pkg::ST_OK;
               pend_value_in  = 16'd0;
               pend_sector_in = 32'd0;
               case (req_ch.command)
                  fccm_pkg::CMD_READ: begin
                     if (fccm_pkg::in_table(req_ch.cluster)) begin
                        mem_re   = 1'b1;
                        mem_addr = req_ch.cluster[IDX_W-1:0];
                        state_in = S_RD_DATA;
                     end else begin
                        pend_status_in = fccm_pkg::ST_RANGE;
                        state_in       = S_RESP;
                     end
                  end
                  fccm_pkg::CMD_WRITE: begin
                     if (fccm_pkg::in_table(req_ch.cluster)) begin
                        mem_we    = 1'b1;
                        mem_addr  = req_ch.cluster[IDX_W-1:0];
                        mem_wdata = req_ch.entry_value;
                     end else begin
                        pend_status_in = fccm_pkg::ST_RANGE;
                     end
                     state_in = S_RESP;
                  end
                  fccm_pkg::CMD_ALLOC: begin
                     if (req_ch.link_cluster != 16'd0 &&
                         !fccm_pkg::in_table(req_ch.link_cluster)) begin
                        pend_status_in = fccm_pkg::ST_RANGE;
                        state_in       = S_RESP;
                     end else begin
                        scan_in    = CNT_W'(2);
                        chk_vld_in = 1'b0;
                        state_in   = S_SCAN;
                     end
                  end
                  default: begin
                     cnt_in   = '0;
                     state_in = S_FREE_CHK;
                  end
               endcase
            end
         end
         S_RD_DATA: begin
            pend_value_in = rd_data_ff;
            prod_in       = 24'(cl_ff - 16'd2) * 24'(sic_ff);
            state_in      = S_RD_SUM;
         end
         S_RD_SUM: begin
            if (cl_ff >= 16'd2) begin
               pend_sector_in = dstart_ff + 32'(prod_ff);
            end
            state_in = S_RESP;
         end
         S_SCAN: begin
            // reads run one entry ahead of the free check
            if (chk_vld_ff && rd_data_ff == fccm_pkg::FREE_ENTRY) begin
               mem_we        = 1'b1;
               mem_addr      = chk_addr_ff;
               mem_wdata     = fccm_pkg::CHAIN_END;
               pend_value_in = 16'(chk_addr_ff);
               state_in      = (prev_ff != 16'd0) ? S_LINK : S_RESP;
            end else if (scan_ff == CNT_W'(fccm_pkg::TABLE_DEPTH)) begin
               pend_status_in = fccm_pkg::ST_FULL;
               state_in       = S_RESP;
            end else begin
               mem_re      = 1'b1;
               mem_addr    = scan_ff[IDX_W-1:0];
               chk_addr_in = scan_ff[IDX_W-1:0];
               chk_vld_in  = 1'b1;
               scan_in     = scan_ff + 1'b1;
            end
         end
         S_LINK: begin
            // overwrites the end mark when prev is the cluster just found
            mem_we    = 1'b1;
            mem_addr  = prev_ff[IDX_W-1:0];
            mem_wdata = pend_value_ff;
            state_in  = S_RESP;
         end
         S_FREE_CHK: begin
            pend_value_in = 16'(cnt_ff);
            if (cl_ff < 16'd2 || cl_ff >= fccm_pkg::CHAIN_LIMIT) begin
               state_in = S_RESP;
            end else if (!fccm_pkg::in_table(cl_ff) ||
                         cnt_ff >= CNT_W'(fccm_pkg::TABLE_DEPTH)) begin
               pend_status_in = fccm_pkg::ST_RANGE;
               state_in       = S_RESP;
            end else begin
               mem_re   = 1'b1;
               mem_addr = cl_ff[IDX_W-1:0];
               state_in = S_FREE_WR;
            end
         end
         S_FREE_WR: begin
            mem_we   = 1'b1;
            mem_addr = cl_ff[IDX_W-1:0];
            cl_in    = rd_data_ff;
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_FREE_CHK;
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_value_in  = pend_value_ff;
               rsp_sector_in = pend_sector_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dstart_ff    <= 32'd0;
         sic_ff       <= 8'd1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == fccm_pkg::CSR_DATA_START) begin
               dstart_ff <= csr_ch.data;
            end else if (csr_ch.index == fccm_pkg::CSR_SECTORS) begin
               sic_ff <= csr_ch.data[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cl_ff          <= cl_in;
      prev_ff        <= prev_in;
      scan_ff        <= scan_in;
      chk_addr_ff    <= chk_addr_in;
      cnt_ff         <= cnt_in;
      prod_ff        <= prod_in;
      cmd_ff         <= cmd_in;
      pend_status_ff <= pend_status_in;
      pend_value_ff  <= pend_value_in;
      pend_sector_ff <= pend_sector_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_sector_ff  <= rsp_sector_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ch.ready)
      else $error("command channel still ready after taking an item");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && slot_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished item not placed in the result register");

   a_free_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE_CHK || state_ff == S_FREE_WR) |->
         cnt_ff <= CNT_W'(fccm_pkg::TABLE_DEPTH))
      else $error("free walk went past the table depth");

   a_alloc_above_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && cmd_ff == fccm_pkg::CMD_ALLOC &&
       pend_status_ff == fccm_pkg::ST_OK) |-> pend_value_ff >= 16'd2)
      else $error("allocate picked cluster zero or one");

endmodule
